FILE: rtl/jqst_pkg.sv
// Shared types and constants for the job queue service timer.
// Holds the request/result structs, the controller/datapath link and queue sizing.
// No dependencies.
package jqst_pkg;

  // Queue sizing (depth must be a power of two: pointers wrap by truncation)
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned QADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W      = QADDR_W + 1;

  // Field widths
  localparam int unsigned PAGES_W   = 5;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned SVC_W     = 11;
  localparam int unsigned WAIT_W    = 16;
  localparam int unsigned MEAN_W    = 24;
  localparam int unsigned TOTAL_W   = 48;
  localparam int unsigned JOBS_W    = 32;
  localparam int unsigned RATE_W    = 8;
  localparam int unsigned ENTRY_W   = STAMP_W + PAGES_W;

  // Serial divider sizing
  localparam int unsigned DIV_REM_W = 32;
  localparam int unsigned DIV_LOW_W = 24;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [PAGES_W-1:0] MAX_PAGES     = 5'd20;
  localparam logic [5:0]         SECS_PER_MIN  = 6'd60;
  localparam logic [RATE_W-1:0]  PAGE_RATE_RST = 8'd5;

  // Quotient bits per divide
  localparam logic [DIV_CNT_W-1:0] SVC_STEPS  = 5'd11;
  localparam logic [DIV_CNT_W-1:0] MEAN_STEPS = 5'd24;

  // One tick request
  typedef struct packed {
    logic               arrival;
    logic [PAGES_W-1:0] job_pages;
    logic               final_tick;
  } in_req_t;

  // One tick result
  typedef struct packed {
    logic              job_started;
    logic [WAIT_W-1:0] wait_seconds;
    logic              server_busy;
    logic [6:0]        queue_count;
    logic              arrival_dropped;
    logic [MEAN_W-1:0] mean_wait;
    logic              run_end;
  } out_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // take request, queue arrival
    logic job_start;  // pop head job, start service divide
    logic advance;    // countdown, start mean divide
    logic finish;     // latch result, advance or clear state
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic start_ok;   // server idle and queue not empty
    logic div_done;   // serial divider idle
  } dp_stat_t;

endpackage

FILE: rtl/jqst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
module jqst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/jqst_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on jqst_pkg for widths.
module jqst_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  logic [jqst_pkg::DIV_REM_W-1:0]  rem_init,   // dividend bits above the quotient
  input  logic [jqst_pkg::DIV_LOW_W-1:0]  low_init,   // remaining bits, MSB first
  input  logic [jqst_pkg::DIV_REM_W-1:0]  divisor,
  input  logic [jqst_pkg::DIV_CNT_W-1:0]  steps,
  output logic                            done,
  output logic [jqst_pkg::DIV_LOW_W-1:0]  quotient
);

  logic [jqst_pkg::DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [jqst_pkg::DIV_LOW_W-1:0] low_r, low_nxt;
  logic [jqst_pkg::DIV_LOW_W-1:0] q_r, q_nxt;
  logic [jqst_pkg::DIV_REM_W-1:0] div_r, div_nxt;
  logic [jqst_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [jqst_pkg::DIV_REM_W+1:0] diff;
  logic                           ge;

  // trial subtract of shifted remainder; remainder stays below divisor
  assign diff = {1'b0, rem_r, low_r[jqst_pkg::DIV_LOW_W-1]} - {2'b00, div_r};
  assign ge   = ~diff[jqst_pkg::DIV_REM_W+1];

  always_comb begin
    rem_nxt = rem_r;
    low_nxt = low_r;
    q_nxt   = q_r;
    div_nxt = div_r;
    cnt_nxt = cnt_r;
    if (load) begin
      rem_nxt = rem_init;
      low_nxt = low_init;
      q_nxt   = '0;
      div_nxt = divisor;
      cnt_nxt = steps;
    end else if (cnt_r != '0) begin
      rem_nxt = ge ? diff[jqst_pkg::DIV_REM_W-1:0]
                   : {rem_r[jqst_pkg::DIV_REM_W-2:0], low_r[jqst_pkg::DIV_LOW_W-1]};
      low_nxt = {low_r[jqst_pkg::DIV_LOW_W-2:0], 1'b0};
      q_nxt   = {q_r[jqst_pkg::DIV_LOW_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    div_r <= div_nxt;
  end

  assign done     = (cnt_r == '0);
  assign quotient = q_r;

endmodule

FILE: rtl/jqst_dp.sv
// Datapath: queue RAM, pointers, service countdown, wait statistics, result register.
// Depends on jqst_pkg, jqst_ram and jqst_div.
module jqst_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  jqst_pkg::dp_cmd_t              cmd,
  output jqst_pkg::dp_stat_t             stat,
  input  jqst_pkg::in_req_t              in_data,
  input  logic                           cfg_we,
  input  logic [jqst_pkg::RATE_W-1:0]    cfg_wdata,
  output jqst_pkg::out_res_t             out_data
);

  logic [jqst_pkg::RATE_W-1:0]   page_rate_r, page_rate_nxt;
  logic [jqst_pkg::QADDR_W-1:0]  head_r, head_nxt;
  logic [jqst_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic [jqst_pkg::STAMP_W-1:0]  tick_r, tick_nxt;
  logic [jqst_pkg::SVC_W-1:0]    svc_left_r, svc_left_nxt;
  logic                          working_r, working_nxt;
  logic [jqst_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [jqst_pkg::JOBS_W-1:0]   jobs_r, jobs_nxt;
  logic                          started_r, started_nxt;
  logic [jqst_pkg::WAIT_W-1:0]   wait_r, wait_nxt;
  logic                          drop_r, drop_nxt;
  logic                          last_r, last_nxt;
  jqst_pkg::out_res_t            out_r, out_nxt;

  logic [jqst_pkg::PAGES_W-1:0]  pages_clamp;
  logic                          q_full;
  logic                          ram_we;
  logic [jqst_pkg::QADDR_W-1:0]  tail;
  logic [jqst_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [jqst_pkg::STAMP_W-1:0]  head_stamp;
  logic [jqst_pkg::PAGES_W-1:0]  head_pages;
  logic [jqst_pkg::STAMP_W-1:0]  waited;
  logic [jqst_pkg::SVC_W-1:0]    work_sec;
  logic [jqst_pkg::RATE_W-1:0]   rate_eff;
  logic [jqst_pkg::SVC_W-1:0]    svc_cur;
  logic                          busy_cur;

  logic                           div_load;
  logic [jqst_pkg::DIV_REM_W-1:0] div_rem_init;
  logic [jqst_pkg::DIV_LOW_W-1:0] div_low_init;
  logic [jqst_pkg::DIV_REM_W-1:0] div_divisor;
  logic [jqst_pkg::DIV_CNT_W-1:0] div_steps;
  logic                           div_done;
  logic [jqst_pkg::DIV_LOW_W-1:0] div_q;

  // arrival side
  assign pages_clamp = (in_data.job_pages > jqst_pkg::MAX_PAGES) ? jqst_pkg::MAX_PAGES
                                                                 : in_data.job_pages;
  assign q_full = (fill_r == jqst_pkg::FILL_W'(jqst_pkg::QUEUE_DEPTH));
  assign tail   = head_r + fill_r[jqst_pkg::QADDR_W-1:0];
  assign ram_we = cmd.accept & in_data.arrival & ~q_full;

  jqst_ram #(
    .WIDTH (jqst_pkg::ENTRY_W),
    .DEPTH (jqst_pkg::QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata ({tick_r, pages_clamp}),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // head entry; registered read of head_r, sampled when the job starts in ST_SVC_LD
  assign head_stamp = ram_rdata[jqst_pkg::ENTRY_W-1:jqst_pkg::PAGES_W];
  assign head_pages = ram_rdata[jqst_pkg::PAGES_W-1:0];
  assign waited     = tick_r - head_stamp;

  // service work in seconds: pages * 60, at most 1200
  assign work_sec = jqst_pkg::SVC_W'({6'd0, head_pages} * jqst_pkg::SVC_W'(jqst_pkg::SECS_PER_MIN));
  assign rate_eff = (page_rate_r == '0) ? jqst_pkg::RATE_W'(1) : page_rate_r;

  // shared divider operand select: service time or running mean
  always_comb begin
    div_load     = cmd.job_start | cmd.advance;
    div_rem_init = '0;
    div_low_init = {work_sec, {(jqst_pkg::DIV_LOW_W - jqst_pkg::SVC_W){1'b0}}};
    div_divisor  = {{(jqst_pkg::DIV_REM_W - jqst_pkg::RATE_W){1'b0}}, rate_eff};
    div_steps    = jqst_pkg::SVC_STEPS;
    if (cmd.advance) begin
      // (total << 8) / jobs; quotient always fits 24 bits since each wait <= 65535
      div_rem_init = total_r[jqst_pkg::TOTAL_W-1:16];
      div_low_init = {total_r[15:0], 8'd0};
      div_divisor  = jobs_r;
      div_steps    = jqst_pkg::MEAN_STEPS;
    end
  end

  jqst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .rem_init (div_rem_init),
    .low_init (div_low_init),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  // service time from the divider (max 1200, below the 2047 ceiling)
  assign svc_cur  = started_r ? div_q[jqst_pkg::SVC_W-1:0] : svc_left_r;
  assign busy_cur = started_r | working_r;

  // next state
  always_comb begin
    page_rate_nxt = page_rate_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    tick_nxt      = tick_r;
    svc_left_nxt  = svc_left_r;
    working_nxt   = working_r;
    total_nxt     = total_r;
    jobs_nxt      = jobs_r;
    started_nxt   = started_r;
    wait_nxt      = wait_r;
    drop_nxt      = drop_r;
    last_nxt      = last_r;
    out_nxt       = out_r;

    if (cfg_we) begin
      page_rate_nxt = cfg_wdata;
    end

    // take request; queue arrival unless full
    if (cmd.accept) begin
      started_nxt = 1'b0;
      wait_nxt    = '0;
      last_nxt    = in_data.final_tick;
      drop_nxt    = in_data.arrival & q_full;
      if (ram_we) begin
        fill_nxt = fill_r + 1'b1;
      end
    end

    // pop head job, record its saturated wait
    if (cmd.job_start) begin
      started_nxt = 1'b1;
      head_nxt    = head_r + 1'b1;
      fill_nxt    = fill_r - 1'b1;
      wait_nxt    = (waited[jqst_pkg::STAMP_W-1:jqst_pkg::WAIT_W] != '0) ? '1
                                                                       : waited[jqst_pkg::WAIT_W-1:0];
      if (jobs_r != '1) begin
        total_nxt = total_r + jqst_pkg::TOTAL_W'(wait_nxt);
        jobs_nxt  = jobs_r + 1'b1;
      end
    end

    // one tick of service countdown
    if (cmd.advance && busy_cur) begin
      if (svc_cur <= jqst_pkg::SVC_W'(1)) begin
        svc_left_nxt = '0;
        working_nxt  = 1'b0;
      end else begin
        svc_left_nxt = svc_cur - 1'b1;
        working_nxt  = 1'b1;
      end
    end

    // latch result; final tick returns queue and statistics to reset
    if (cmd.finish) begin
      out_nxt.job_started     = started_r;
      out_nxt.wait_seconds    = wait_r;
      out_nxt.server_busy     = working_r;
      out_nxt.queue_count     = fill_r;
      out_nxt.arrival_dropped = drop_r;
      out_nxt.mean_wait       = (jobs_r == '0) ? '0 : div_q;
      out_nxt.run_end         = last_r;
      tick_nxt                = tick_r + 1'b1;
      if (last_r) begin
        head_nxt     = '0;
        fill_nxt     = '0;
        tick_nxt     = '0;
        svc_left_nxt = '0;
        working_nxt  = 1'b0;
        total_nxt    = '0;
        jobs_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_rate_r <= jqst_pkg::PAGE_RATE_RST;
      head_r      <= '0;
      fill_r      <= '0;
      tick_r      <= '0;
      svc_left_r  <= '0;
      working_r   <= 1'b0;
      total_r     <= '0;
      jobs_r      <= '0;
      started_r   <= 1'b0;
    end else begin
      page_rate_r <= page_rate_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      tick_r      <= tick_nxt;
      svc_left_r  <= svc_left_nxt;
      working_r   <= working_nxt;
      total_r     <= total_nxt;
      jobs_r      <= jobs_nxt;
      started_r   <= started_nxt;
    end
    wait_r <= wait_nxt;
    drop_r <= drop_nxt;
    last_r <= last_nxt;
    out_r  <= out_nxt;
  end

  assign stat.start_ok = ~working_r & (fill_r != '0);
  assign stat.div_done = div_done;
  assign out_data      = out_r;

endmodule

FILE: rtl/jqst_ctrl.sv
// Controller: sequences one tick request through queue read, service divide,
// countdown and mean divide. Depends on jqst_pkg.
module jqst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_strobe,
  output jqst_pkg::dp_cmd_t  cmd,
  input  jqst_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SVC_LD,
    ST_SVC_RUN,
    ST_MEAN_LD,
    ST_MEAN_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;

  // commands decoded from the current state
  assign cmd.accept    = (state_r == ST_IDLE) & start;
  assign cmd.job_start = (state_r == ST_SVC_LD);
  assign cmd.advance   = (state_r == ST_MEAN_LD);
  assign cmd.finish    = (state_r == ST_MEAN_RUN) & stat.div_done;

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = stat.start_ok ? ST_SVC_LD : ST_MEAN_LD;
      end
      ST_SVC_LD: begin
        state_nxt = ST_SVC_RUN;
      end
      ST_SVC_RUN: begin
        if (stat.div_done) begin
          state_nxt = ST_MEAN_LD;
        end
      end
      ST_MEAN_LD: begin
        state_nxt = ST_MEAN_RUN;
      end
      ST_MEAN_RUN: begin
        if (stat.div_done) begin
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;

endmodule

FILE: rtl/job_queue_service_timer_core.sv
// Single-server job queue timer, advanced one one-second tick per request.
// Depends on jqst_pkg, jqst_ctrl and jqst_dp.
//
// Usage:
//   Input: drive in_data and pulse start while busy is low; the request is
//   taken at that edge. Each request is one tick: an optional job arrival with
//   its page count, and a flag marking the last tick of a run.
//   Output: one result per request, shown on out_data for exactly one cycle
//   with out_strobe high. The receiver cannot stall; results must be taken.
//   Config: cfg_we with cfg_wdata writes page_rate; write only while idle.
// Sequence:
//   Every tick passes through ST_READ, ST_MEAN_LD and ST_MEAN_RUN; a tick
//   that starts a job also passes through ST_SVC_LD and ST_SVC_RUN between
//   the queue RAM read and the countdown. One serial divider is shared by the
//   service-time divide (11 quotient bits) and the running-mean divide (24
//   quotient bits), one bit per cycle. A new request may be accepted in the
//   strobe cycle; no request is taken while the previous one is in progress.
// Reset:
//   Synchronous active-low rst_n empties the queue, zeroes the tick count and
//   statistics, idles the server and sets page_rate to 5. The queue RAM is not
//   cleared; only written entries are ever read. A final tick does the same
//   clearing after its result, except that page_rate is kept.
module job_queue_service_timer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  jqst_pkg::in_req_t           in_data,
  output logic                        out_strobe,
  output jqst_pkg::out_res_t          out_data,
  input  logic                        cfg_we,
  input  logic [jqst_pkg::RATE_W-1:0] cfg_wdata
);

  jqst_pkg::dp_cmd_t  cmd;
  jqst_pkg::dp_stat_t stat;

  jqst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .stat       (stat)
  );

  jqst_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

  // a taken request always makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // a result only follows work in progress
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without preceding work");

  // no wait is reported without a job start
  a_wait_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.job_started) |-> (out_data.wait_seconds == '0))
    else $error("wait reported without job start");

  // queue never reports more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.queue_count <= 7'(jqst_pkg::QUEUE_DEPTH)))
    else $error("queue count exceeds depth");

endmodule
